[rtl/bole_pkg.sv]
// ----------------------------------------------------------------------------
// bole_pkg: shared definitions for the bounded ordered list engine
// Field widths, command codes and parameter defaults.
// ----------------------------------------------------------------------------
package bole_pkg;

  localparam int CMD_W = 2;
  localparam int POS_W = 6;
  localparam int CAP_W = 7;

  localparam int DEF_DEPTH     = 64;
  localparam int DEF_KEY_WIDTH = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 2'd0,
    CMD_REMOVE   = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

endpackage

[rtl/bounded_ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: insertion-ordered key list with a capacity limit
// Append, remove-first-match, contains and read-at-position over one memory.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with cmd, key and position. Each
//   request yields one result on out_valid/out_ready: ok, read_value, count
//   and full_res. The capacity register is written on cfg_valid/cfg_ready;
//   any write empties the list (zero is held as 1, values above DEPTH as
//   DEPTH).
//   Request paths, with n keys held: append goes straight to the result;
//   read passes through the memory read to the result, or goes straight
//   there when the position is not below n; contains scans from position 0
//   to the first match or the end of the list; remove scans the same way,
//   then shifts each later key down one place before the result.
//   The block takes one request at a time and is ready again once the
//   result is loaded. All searching and compacting run through the
//   single read/write port of the key memory and one equality compare, one
//   entry per cycle, so the memory port sets the rate.
//   A finished result sits in the output register; the next request is
//   accepted while it waits. If the receiver stalls, the following result
//   is held in the engine until the output register frees up.
//   Reset empties the list and sets capacity to 1; no clearing pass.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine #(
  parameter int DEPTH     = bole_pkg::DEF_DEPTH,
  parameter int KEY_WIDTH = bole_pkg::DEF_KEY_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bole_pkg::CAP_W-1:0]       capacity,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bole_pkg::CMD_W-1:0]       cmd,
  input  logic signed [KEY_WIDTH-1:0]      key,
  input  logic [bole_pkg::POS_W-1:0]       position,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             ok,
  output logic signed [KEY_WIDTH-1:0]      read_value,
  output logic [bole_pkg::CAP_W-1:0]       count,
  output logic                             full_res
);

  localparam int CAP_W   = bole_pkg::CAP_W;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_TOP = (1 << CAP_W) - 1;
  localparam logic [CAP_W-1:0] CAP_LIMIT =
    CAP_W'((DEPTH > CAP_TOP) ? CAP_TOP : DEPTH);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_READ   = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t                 state, state_next;
  logic [CAP_W-1:0]       capacity_q;
  logic [CAP_W-1:0]       entry_count;
  logic [CAP_W-1:0]       scan_idx;
  logic [CAP_W-1:0]       cmp_idx;
  logic                   cmp_vld;
  bole_pkg::cmd_t         cmd_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic                   op_ok;
  logic [KEY_WIDTH-1:0]   op_rv;

  logic [KEY_WIDTH-1:0]   mem [DEPTH];
  logic [KEY_WIDTH-1:0]   mem_q;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  logic [IDX_W-1:0]       mem_ra;
  logic [KEY_WIDTH-1:0]   mem_wd;

  logic                   in_acc;
  logic                   cfg_acc;
  logic                   has_room;
  logic                   pos_ok;
  logic                   scan_more;
  logic                   hit;
  logic                   slot_free;
  logic [CAP_W-1:0]       cap_clamped;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign has_room  = (entry_count < capacity_q);
  assign pos_ok    = (CAP_W'(position) < entry_count);
  assign scan_more = (scan_idx < entry_count);
  // Shared compare: registered memory word against the request key
  assign hit       = cmp_vld && (mem_q == key_q);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    if (capacity == '0) begin
      cap_clamped = CAP_W'(1);
    end else if (capacity > CAP_LIMIT) begin
      cap_clamped = CAP_LIMIT;
    end else begin
      cap_clamped = capacity;
    end
  end

  // Single memory port: append and compaction write, position and scan read
  always_comb begin
    if (state == S_IDLE) begin
      mem_we = in_acc && (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_APPEND) && has_room;
      mem_wa = IDX_W'(entry_count);
      mem_wd = key;
      mem_ra = IDX_W'(position);
    end else begin
      mem_we = (state == S_SHIFT) && cmp_vld;
      mem_wa = IDX_W'(cmp_idx);
      mem_wd = mem_q;
      mem_ra = IDX_W'(scan_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (bole_pkg::cmd_t'(cmd))
            bole_pkg::CMD_APPEND: state_next = S_RESULT;
            bole_pkg::CMD_READ:   state_next = pos_ok ? S_READ : S_RESULT;
            default:              state_next = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_next = (cmd_q == bole_pkg::CMD_REMOVE) ? S_SHIFT : S_RESULT;
        end else if (!cmp_vld && !scan_more) begin
          state_next = S_RESULT;
        end
      end
      S_SHIFT: begin
        if (!cmp_vld && !scan_more) begin
          state_next = S_RESULT;
        end
      end
      S_READ:   state_next = S_RESULT;
      S_RESULT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      capacity_q  <= CAP_W'(1);
      entry_count <= '0;
      cmp_vld     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_acc) begin
        capacity_q  <= cap_clamped;
        entry_count <= '0;
      end
      if ((state == S_RESULT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cmp_vld <= 1'b0;
          if (in_acc && (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_APPEND) && has_room) begin
            entry_count <= entry_count + CAP_W'(1);
          end
        end
        S_SCAN: begin
          if (hit) begin
            // Start compaction one past the match; drop the pending read
            cmp_vld <= 1'b0;
          end else begin
            cmp_vld <= scan_more;
          end
        end
        S_SHIFT: begin
          cmp_vld <= scan_more;
          if (!cmp_vld && !scan_more) begin
            entry_count <= entry_count - CAP_W'(1);
          end
        end
        S_READ: begin
          cmp_vld <= 1'b0;
        end
        S_RESULT: begin
          cmp_vld <= 1'b0;
        end
        default: cmp_vld <= 1'b0;
      endcase
    end
  end

  // Datapath registers: request, scan pointers, pending result
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          cmd_q    <= bole_pkg::cmd_t'(cmd);
          key_q    <= key;
          scan_idx <= '0;
          op_rv    <= '0;
          case (bole_pkg::cmd_t'(cmd))
            bole_pkg::CMD_APPEND: op_ok <= has_room;
            default:              op_ok <= 1'b0;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          op_ok    <= 1'b1;
          scan_idx <= cmp_idx + CAP_W'(1);
        end else if (scan_more) begin
          cmp_idx  <= scan_idx;
          scan_idx <= scan_idx + CAP_W'(1);
        end
      end
      S_SHIFT: begin
        if (scan_more) begin
          // Read slot scan_idx now, write it to scan_idx - 1 next cycle
          cmp_idx  <= scan_idx - CAP_W'(1);
          scan_idx <= scan_idx + CAP_W'(1);
        end
      end
      S_READ: begin
        op_ok <= 1'b1;
        op_rv <= mem_q;
      end
      S_RESULT: begin
        if (slot_free) begin
          ok         <= op_ok;
          read_value <= op_rv;
          count      <= entry_count;
          full_res   <= (entry_count == capacity_q);
        end
      end
      default: op_ok <= 1'b0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_le_cap: assert property (@(posedge clk) disable iff (rst)
    entry_count <= capacity_q)
    else $error("entry count exceeds capacity");

  a_cap_range: assert property (@(posedge clk) disable iff (rst)
    (capacity_q != '0) && (capacity_q <= CAP_LIMIT))
    else $error("capacity register out of range");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (bole_pkg::cmd_t'(cmd) == bole_pkg::CMD_APPEND) && has_room)
    |=> (entry_count == $past(entry_count) + CAP_W'(1)))
    else $error("append did not grow the list");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SHIFT) && !cmp_vld && !scan_more)
    |=> (entry_count == $past(entry_count) - CAP_W'(1)) && (state == S_RESULT))
    else $error("remove did not shrink the list");

  a_shift_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SHIFT) && cmp_vld) |-> (cmp_idx + CAP_W'(1) < entry_count))
    else $error("compaction write past the last entry");

endmodule
